// ===== rtl/bpfa_pkg.sv =====
package bpfa_pkg;

	localparam int DefNumPages  = 8192;
	localparam int DefPageBytes = 4096;

	localparam int ReqW      = 2;
	localparam int PageIdxW  = 13;
	localparam int AddrW     = 25;
	localparam int WordBits  = 64;
	localparam logic [PageIdxW-1:0] FloorReset = 13'd528;

	typedef enum logic [ReqW-1:0] {
		REQ_FREE         = 2'd0,
		REQ_MARK         = 2'd1,
		REQ_ALLOC_KERNEL = 2'd2,
		REQ_ALLOC_ZERO   = 2'd3
	} req_t;

	// Program counter of the sequencer; the order matters where a step falls through.
	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_FM_RD   = 4'd1,
		ST_FM_WR   = 4'd2,
		ST_AL_CHK  = 4'd3,
		ST_AL_RD   = 4'd4,
		ST_AL_TST  = 4'd5,
		ST_AL_BYTE = 4'd6,
		ST_AL_BIT  = 4'd7,
		ST_AL_WR   = 4'd8,
		ST_RESULT  = 4'd9
	} step_t;

	typedef enum logic [2:0] {
		COND_NEVER   = 3'd0,
		COND_ALWAYS  = 3'd1,
		COND_BADPAGE = 3'd2,
		COND_END     = 3'd3,
		COND_FULL    = 3'd4
	} cond_t;

	typedef enum logic [1:0] {
		WR_NONE  = 2'd0,
		WR_FM    = 2'd1,
		WR_ALLOC = 2'd2
	} wsel_t;

	typedef struct packed {
		logic  rd;
		wsel_t wr;
		logic  ld_word;
		logic  ld_byte;
		logic  ld_bit;
		logic  set_ok;
		logic  fire;
		cond_t cond;
		step_t target;
	} ctrl_t;

	function automatic ctrl_t ucode(input step_t step);
		ctrl_t c;
		c = '{rd: 1'b0, wr: WR_NONE, ld_word: 1'b0, ld_byte: 1'b0, ld_bit: 1'b0,
			set_ok: 1'b0, fire: 1'b0, cond: COND_NEVER, target: ST_IDLE};
		unique case (step)
			ST_IDLE: begin
			end
			ST_FM_RD: begin
				c.rd     = 1'b1;
				c.cond   = COND_BADPAGE;
				c.target = ST_RESULT;
			end
			ST_FM_WR: begin
				c.wr     = WR_FM;
				c.set_ok = 1'b1;
				c.cond   = COND_ALWAYS;
				c.target = ST_RESULT;
			end
			ST_AL_CHK: begin
				c.cond   = COND_END;
				c.target = ST_RESULT;
			end
			ST_AL_RD: begin
				c.rd = 1'b1;
			end
			ST_AL_TST: begin
				c.ld_word = 1'b1;
				c.cond    = COND_FULL;
				c.target  = ST_AL_CHK;
			end
			ST_AL_BYTE: begin
				c.ld_byte = 1'b1;
			end
			ST_AL_BIT: begin
				c.ld_bit = 1'b1;
			end
			ST_AL_WR: begin
				c.wr     = WR_ALLOC;
				c.set_ok = 1'b1;
			end
			ST_RESULT: begin
				c.fire   = 1'b1;
				c.cond   = COND_ALWAYS;
				c.target = ST_IDLE;
			end
			default: begin
				c.cond   = COND_ALWAYS;
				c.target = ST_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/bpfa_ram.sv =====
module bpfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/bitmap_page_frame_allocator_top.sv =====
// Channel  | Signals                           | Direction | Beat taken when
// ---------+-----------------------------------+-----------+--------------------------
// request  | start, req_type, page_index, busy | in        | start high and busy low
// result   | done, ok, page_address            | out       | done high (one cycle)
// config   | cfg_valid, cfg_data, cfg_ready    | in        | cfg_valid and cfg_ready high
//
// A free or mark steps through a RAM read, a write-back and the result; a refused page
// skips the write. An allocation visits each bitmap word in a check, a RAM read and a test
// (paced by the single registered read port), then picks the byte and the bit, writes it
// back and reports; a failed search ends at the check and reports.
// After reset every page reads as used: a per-row valid bit overlays all ones on rows
// never written. The result is shown for one cycle only and cannot be stalled.
module bitmap_page_frame_allocator_top #(
	parameter int NUM_PAGES  = bpfa_pkg::DefNumPages,
	parameter int PAGE_BYTES = bpfa_pkg::DefPageBytes
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bpfa_pkg::ReqW-1:0]     req_type,
	input  logic [bpfa_pkg::PageIdxW-1:0] page_index,
	output logic                          done,
	output logic                          ok,
	output logic [bpfa_pkg::AddrW-1:0]    page_address,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpfa_pkg::PageIdxW-1:0] cfg_data
);

	localparam int MapWords = (NUM_PAGES + bpfa_pkg::WordBits - 1) / bpfa_pkg::WordBits;
	localparam int WW       = (MapWords > 1) ? $clog2(MapWords) : 1;
	localparam int PW       = WW + 6;
	localparam int ProdW    = (PW + 17 > bpfa_pkg::AddrW) ? PW + 17 : bpfa_pkg::AddrW;
	localparam int WB       = bpfa_pkg::WordBits;

	bpfa_pkg::step_t step_q;
	bpfa_pkg::ctrl_t ctrl;
	bpfa_pkg::req_t  req_q;

	logic [bpfa_pkg::PageIdxW-1:0] floor_q;
	logic [WW:0]    row_q;
	logic [5:0]     off_q;
	logic [2:0]     byte_q;
	logic [2:0]     fbit_q;
	logic           pg_ok_q;
	logic           ok_q;
	logic [bpfa_pkg::AddrW-1:0] addr_q;
	logic [WB-1:0]  word_q;
	logic [WB-1:0]  mword_q;
	logic [(2**WW)-1:0] valid_q;

	logic [WB-1:0]  rdata;
	logic [WB-1:0]  eff;
	logic [WB-1:0]  masked;
	logic           full;
	logic           cond_hit;
	logic           accept;
	logic           ram_we;
	logic [WB-1:0]  wdata;
	logic [2:0]     byte_sel;
	logic [2:0]     bit_sel;
	logic [7:0]     cur_byte;
	logic [PW-1:0]  found;
	logic [ProdW-1:0] prod;
	logic [bpfa_pkg::PageIdxW-1:0] start_pg;
	logic           fm_req;
	logic           floor_bad;

	assign ctrl      = bpfa_pkg::ucode(step_q);
	assign busy      = (step_q != bpfa_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = ctrl.fire;
	assign ok        = ok_q;
	assign page_address = addr_q;

	assign fm_req    = (req_type == bpfa_pkg::REQ_FREE) || (req_type == bpfa_pkg::REQ_MARK);
	assign floor_bad = (req_type == bpfa_pkg::REQ_ALLOC_KERNEL)
		&& ({19'd0, floor_q} >= 32'(NUM_PAGES));
	assign start_pg  = (req_type == bpfa_pkg::REQ_ALLOC_KERNEL) ? floor_q : '0;

	// Rows never written read as all ones through their valid bit.
	assign eff    = valid_q[row_q[WW-1:0]] ? rdata : '1;
	assign masked = eff | ~({WB{1'b1}} << off_q);
	assign full   = &masked;

	always_comb begin
		unique case (ctrl.cond)
			bpfa_pkg::COND_NEVER:   cond_hit = 1'b0;
			bpfa_pkg::COND_ALWAYS:  cond_hit = 1'b1;
			bpfa_pkg::COND_BADPAGE: cond_hit = !pg_ok_q;
			bpfa_pkg::COND_END:     cond_hit = (row_q == (WW+1)'(MapWords));
			bpfa_pkg::COND_FULL:    cond_hit = full;
			default:                cond_hit = 1'b0;
		endcase
	end

	// Lowest byte of the masked word that still has a free page.
	always_comb begin
		byte_sel = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (mword_q[i*8 +: 8] != 8'hFF) begin
				byte_sel = 3'(i);
			end
		end
	end

	assign cur_byte = mword_q[{byte_q, 3'b000} +: 8];

	always_comb begin
		bit_sel = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!cur_byte[i]) begin
				bit_sel = 3'(i);
			end
		end
	end

	assign found = {row_q[WW-1:0], byte_q, fbit_q};
	assign prod  = ProdW'(found) * ProdW'(PAGE_BYTES);

	always_comb begin
		ram_we = 1'b0;
		wdata  = eff;
		unique case (ctrl.wr)
			bpfa_pkg::WR_NONE: begin
			end
			bpfa_pkg::WR_FM: begin
				ram_we = 1'b1;
				if (req_q == bpfa_pkg::REQ_FREE) begin
					wdata = eff & ~(WB'(1) << off_q);
				end else begin
					wdata = eff | (WB'(1) << off_q);
				end
			end
			bpfa_pkg::WR_ALLOC: begin
				ram_we = 1'b1;
				wdata  = word_q | (WB'(1) << {byte_q, fbit_q});
			end
			default: begin
			end
		endcase
	end

	bpfa_ram #(
		.WIDTH (WB),
		.DEPTH (MapWords)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q[WW-1:0]),
		.wdata (wdata),
		.re    (ctrl.rd),
		.raddr (row_q[WW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= bpfa_pkg::ST_IDLE;
			floor_q <= bpfa_pkg::FloorReset;
			valid_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				floor_q <= cfg_data;
			end
			if (ram_we) begin
				valid_q[row_q[WW-1:0]] <= 1'b1;
			end
			if (step_q == bpfa_pkg::ST_IDLE) begin
				if (accept) begin
					if (fm_req) begin
						step_q <= bpfa_pkg::ST_FM_RD;
					end else if (floor_bad) begin
						step_q <= bpfa_pkg::ST_RESULT;
					end else begin
						step_q <= bpfa_pkg::ST_AL_CHK;
					end
				end
			end else if (cond_hit) begin
				step_q <= ctrl.target;
			end else begin
				step_q <= bpfa_pkg::step_t'(4'(step_q + 4'd1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= bpfa_pkg::req_t'(req_type);
			ok_q   <= 1'b0;
			addr_q <= '0;
			if (fm_req) begin
				row_q   <= (WW+1)'(page_index >> 6);
				off_q   <= page_index[5:0];
				pg_ok_q <= (page_index != '0) && ({19'd0, page_index} < 32'(NUM_PAGES));
			end else begin
				row_q   <= (WW+1)'(start_pg >> 6);
				off_q   <= start_pg[5:0];
				pg_ok_q <= 1'b1;
			end
		end else begin
			if (ctrl.ld_word) begin
				word_q  <= eff;
				mword_q <= masked;
			end
			// A full word moves the scan on to the start of the next word.
			if (ctrl.cond == bpfa_pkg::COND_FULL && full) begin
				row_q <= row_q + (WW+1)'(1);
				off_q <= '0;
			end
			if (ctrl.ld_byte) begin
				byte_q <= byte_sel;
			end
			if (ctrl.ld_bit) begin
				fbit_q <= bit_sel;
			end
			if (ctrl.set_ok) begin
				ok_q <= 1'b1;
			end
			if (ctrl.wr == bpfa_pkg::WR_ALLOC) begin
				addr_q <= prod[bpfa_pkg::AddrW-1:0];
			end
		end
	end

endmodule

// ===== tb/bpfa_frame_checker.sv =====
`timescale 1ns / 100ps

module bpfa_frame_checker
	import bpfa_pkg::*;
#(
	parameter int NUM_PAGES  = DefNumPages,
	parameter int PAGE_BYTES = DefPageBytes
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [ReqW-1:0]     req_type,
	input  logic [PageIdxW-1:0] page_index,
	input  logic                done,
	input  logic                ok,
	input  logic [AddrW-1:0]    page_address,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [PageIdxW-1:0] cfg_data,
	output int                  mismatches,
	output int                  outstanding,
	output int                  results_seen,
	output int                  grants,
	output int                  refusals
);

	typedef struct packed {
		logic             ok;
		logic [AddrW-1:0] addr;
	} frame_result_t;

	frame_result_t       expected_frames[$];
	logic [NUM_PAGES-1:0] used_pages;
	logic [PageIdxW-1:0]  floor_page;
	int                   err_count    = 0;
	int                   seen_count   = 0;
	int                   grant_count  = 0;
	int                   refuse_count = 0;

	function automatic frame_result_t apply_request(input req_t kind,
			input logic [PageIdxW-1:0] page);
		frame_result_t res;
		int            pg;
		res = '0;
		if (kind == REQ_FREE || kind == REQ_MARK) begin
			// Page zero is reserved and never changes hands.
			if (page != '0 && int'(page) < NUM_PAGES) begin
				used_pages[page] = (kind == REQ_MARK);
				res.ok = 1'b1;
			end
		end else begin
			pg = (kind == REQ_ALLOC_KERNEL) ? int'(floor_page) : 0;
			while (pg < NUM_PAGES && !res.ok) begin
				if (!used_pages[pg]) begin
					used_pages[pg] = 1'b1;
					res.ok = 1'b1;
					res.addr = AddrW'(pg * PAGE_BYTES);
				end
				pg++;
			end
			if (res.ok)
				grant_count++;
			else
				refuse_count++;
		end
		return res;
	endfunction

	task automatic flag(input string what, input logic [AddrW-1:0] want,
			input logic [AddrW-1:0] got);
		if (err_count < 10)
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			used_pages = '1;
			floor_page = FloorReset;
			expected_frames.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				floor_page = cfg_data;
			// A result can never belong to a request taken at the same edge.
			if (done) begin
				seen_count++;
				if (expected_frames.size() == 0) begin
					flag("result beat with nothing pending, address", '0, page_address);
				end else begin
					want = expected_frames.pop_front();
					if (ok !== want.ok)
						flag("ok", AddrW'(want.ok), AddrW'(ok));
					if (page_address !== want.addr)
						flag("page_address", want.addr, page_address);
				end
			end
			if (start && !busy)
				expected_frames.push_back(apply_request(req_t'(req_type), page_index));
			mismatches   <= err_count;
			outstanding  <= expected_frames.size();
			results_seen <= seen_count;
			grants       <= grant_count;
			refusals     <= refuse_count;
		end
	end

endmodule

// ===== tb/tb_bitmap_page_frame_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_bitmap_page_frame_allocator_top;
	import bpfa_pkg::*;

	localparam int WatchdogLimit = 4000;
	localparam int TailCycles    = 400;
	localparam int NumPhases     = 8;
	localparam int PhaseItems    = 250;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                start      = 1'b0;
	logic [ReqW-1:0]     req_type   = '0;
	logic [PageIdxW-1:0] page_index = '0;
	logic                cfg_valid  = 1'b0;
	logic [PageIdxW-1:0] cfg_data   = '0;
	logic                busy;
	logic                done;
	logic                ok;
	logic                cfg_ready;
	logic [AddrW-1:0]    page_address;

	int                  mismatches;
	int                  outstanding;
	int                  results_seen;
	int                  grants;
	int                  refusals;
	int                  quiet_cycles = 0;
	int                  floor_writes = 0;
	bit                  gaps_on      = 1'b1;
	logic [PageIdxW-1:0] cur_floor    = FloorReset;

	bitmap_page_frame_allocator_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.page_index   (page_index),
		.done         (done),
		.ok           (ok),
		.page_address (page_address),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	bpfa_frame_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.page_index   (page_index),
		.done         (done),
		.ok           (ok),
		.page_address (page_address),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.grants       (grants),
		.refusals     (refusals)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Any beat on any channel resets the count; a long silence means a hang.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("tb_bitmap_page_frame_allocator_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int gap_len();
		int n;
		n = 0;
		if (gaps_on)
			while ($urandom_range(0, 99) < 21)
				n++;
		return n;
	endfunction

	task automatic send_req(input req_t kind, input logic [PageIdxW-1:0] page);
		int n;
		n = gap_len();
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
		start      <= 1'b1;
		req_type   <= kind;
		page_index <= page;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_floor(input logic [PageIdxW-1:0] value);
		drain();
		repeat (gap_len()) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_floor = value;
		floor_writes++;
	endtask

	function automatic req_t pick_kind();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return REQ_FREE;
		if (roll < 50)
			return REQ_MARK;
		if (roll < 75)
			return REQ_ALLOC_KERNEL;
		return REQ_ALLOC_ZERO;
	endfunction

	// Most pages fall in a 256-page window so that frees and allocations meet.
	function automatic logic [PageIdxW-1:0] pick_page(input int unsigned lo);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return PageIdxW'(lo + $urandom_range(0, 255));
		if (roll < 85)
			return PageIdxW'($urandom);
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return cur_floor;
			3: return cur_floor - 1'b1;
			default: return cur_floor + 1'b1;
		endcase
	endfunction

	initial begin
		int                  phase;
		int                  k;
		int unsigned         win_lo;
		logic [PageIdxW-1:0] next_floor;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every page starts out used, so both kinds of allocation must come back empty.
		send_req(REQ_ALLOC_ZERO, '1);
		send_req(REQ_ALLOC_KERNEL, '0);
		send_req(REQ_FREE, '0);
		send_req(REQ_MARK, '0);
		send_req(REQ_FREE, '1);
		send_req(REQ_FREE, '1);
		send_req(REQ_FREE, 13'd1);
		send_req(REQ_MARK, 13'd1);
		send_req(REQ_MARK, 13'd1);
		send_req(REQ_ALLOC_KERNEL, PageIdxW'($urandom));
		send_req(REQ_ALLOC_KERNEL, PageIdxW'($urandom));
		send_req(REQ_FREE, 13'd527);
		send_req(REQ_FREE, 13'd529);
		send_req(REQ_ALLOC_KERNEL, PageIdxW'($urandom));
		send_req(REQ_ALLOC_ZERO, PageIdxW'($urandom));

		// An unaligned floor must skip the free pages below it in its own word.
		write_floor(13'd100);
		send_req(REQ_FREE, 13'd99);
		send_req(REQ_FREE, 13'd130);
		send_req(REQ_ALLOC_KERNEL, PageIdxW'($urandom));
		send_req(REQ_ALLOC_ZERO, PageIdxW'($urandom));

		write_floor('1);
		send_req(REQ_FREE, '1);
		send_req(REQ_ALLOC_KERNEL, PageIdxW'($urandom));
		send_req(REQ_ALLOC_KERNEL, PageIdxW'($urandom));

		write_floor('0);
		send_req(REQ_FREE, 13'd64);
		send_req(REQ_ALLOC_KERNEL, PageIdxW'($urandom));

		for (phase = 0; phase < NumPhases; phase++) begin
			case (phase)
				0: next_floor = FloorReset;
				1: next_floor = '1;
				2: next_floor = PageIdxW'($urandom_range(1, 8190)) | 13'd1;
				3: next_floor = PageIdxW'(64 * $urandom_range(1, 127));
				4: next_floor = '0;
				5: next_floor = PageIdxW'($urandom);
				6: next_floor = 13'd4095;
				default: next_floor = 13'd1;
			endcase
			write_floor(next_floor);
			gaps_on = (phase != 3);
			if (phase % 2 == 0)
				win_lo = cur_floor;
			else
				win_lo = $urandom_range(0, DefNumPages - 256);
			for (k = 0; k < PhaseItems; k++)
				send_req(pick_kind(), pick_page(win_lo));
		end

		drain();
		repeat (TailCycles) @(posedge clk);

		$display("Checked %0d results: %0d pages granted, %0d allocations refused.",
			results_seen, grants, refusals);
		$display("The kernel floor took %0d settings, among them page 0 and the top page.",
			floor_writes);
		if (mismatches == 0)
			$display("tb_bitmap_page_frame_allocator_top: PASS");
		else
			$display("tb_bitmap_page_frame_allocator_top: FAIL");
		$finish;
	end

endmodule
